// ----- hw/rtl/sipc_pkg.sv -----
// ----------------------------------------------------------------------------
// sipc_pkg
// Shared types and constants for the single indel pattern counter.
// ----------------------------------------------------------------------------
package sipc_pkg;

  // Pattern and text geometry.
  localparam int MAX_PATTERN = 16;
  localparam int WIN_DEPTH   = MAX_PATTERN + 1;
  localparam int BASE_W      = 2;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int SEEN_W      = $clog2(WIN_DEPTH + 1);
  localparam int PAT_W       = 32;

  // Counter and port widths.
  localparam int COUNT_BITS  = 32;
  localparam int OUT_W       = 32;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 3 * OUT_W;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BASES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN   = 1'b1;

  // Base codes.
  localparam logic [BASE_W-1:0] BASE_A = 2'd0;
  localparam logic [BASE_W-1:0] BASE_G = 2'd1;
  localparam logic [BASE_W-1:0] BASE_C = 2'd2;
  localparam logic [BASE_W-1:0] BASE_T = 2'd3;

  typedef logic [BASE_W-1:0]     base_t;
  typedef logic [LEN_W-1:0]      len_t;
  typedef logic [SEEN_W-1:0]     seen_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam count_t COUNT_MAX = '1;

  // Per-base match flags from the comparator to the counters.
  typedef struct packed {
    logic exact;
    logic deletion;
    logic insertion;
  } hit_t;

endpackage

// ----- hw/rtl/sipc_match.sv -----
// ----------------------------------------------------------------------------
// sipc_match
// Compares the text window ending at the newest base with the pattern and
// with its one-deletion and one-insertion variants.
// ----------------------------------------------------------------------------
module sipc_match (
  input  sipc_pkg::base_t                      base,
  input  sipc_pkg::base_t [sipc_pkg::MAX_PATTERN-1:0] hist,
  input  logic [sipc_pkg::PAT_W-1:0]           pattern_bases,
  input  sipc_pkg::len_t                       len,
  input  sipc_pkg::seen_t                      seen,
  output sipc_pkg::hit_t                       hit
);
  import sipc_pkg::*;

  // True if some split point s (0..n) has every pre_ok below s and every
  // post_ok from s up to n-1 set: the longer string loses one base at s.
  function automatic logic split_match(input logic [MAX_PATTERN-1:0] pre_ok,
                                       input logic [MAX_PATTERN-1:0] post_ok,
                                       input len_t n);
    logic found;
    logic all_pre;
    logic all_post;
    found = 1'b0;
    for (int s = 0; s <= MAX_PATTERN; s++) begin
      all_pre  = 1'b1;
      all_post = 1'b1;
      for (int j = 0; j < MAX_PATTERN; j++) begin
        if (j < s) begin
          all_pre = all_pre & pre_ok[j];
        end else if (j < int'(n)) begin
          all_post = all_post & post_ok[j];
        end
      end
      if ((s <= int'(n)) && all_pre && all_post) begin
        found = 1'b1;
      end
    end
    return found;
  endfunction

  base_t [WIN_DEPTH-1:0]   win;
  base_t [MAX_PATTERN-1:0] rpat;
  logic [MAX_PATTERN-1:0]  eq_same;
  logic [MAX_PATTERN-1:0]  eq_ahead;
  logic [MAX_PATTERN-1:0]  eq_behind;
  logic [MAX_PATTERN-1:0]  len_mask;
  logic [SEEN_W:0]         seen_x;
  logic [SEEN_W:0]         len_x;

  // Window with the newest base at index 0.
  always_comb begin
    win[0] = base;
    for (int j = 1; j < WIN_DEPTH; j++) begin
      win[j] = hist[j-1];
    end
  end

  // Pattern reversed so that entry j lines up with window entry j.
  always_comb begin
    logic [LEN_W-1:0] idx;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      idx     = LEN_W'(len - LEN_W'(1) - LEN_W'(j));
      rpat[j] = (j < int'(len)) ? pattern_bases[2*idx[LEN_W-2:0] +: BASE_W] : BASE_A;
    end
  end

  // Per-position equalities, aligned and shifted by one either way.
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      eq_same[j]   = (win[j] == rpat[j]);
      eq_behind[j] = (win[j+1] == rpat[j]);
      len_mask[j]  = (j < int'(len));
      if (j + 1 < MAX_PATTERN) begin
        eq_ahead[j] = (win[j] == rpat[j+1]);
      end else begin
        eq_ahead[j] = 1'b0;
      end
    end
  end

  assign seen_x = {1'b0, seen};
  assign len_x  = {{(SEEN_W + 1 - LEN_W){1'b0}}, len};

  // Match flags, each gated by enough text history.
  always_comb begin
    hit.exact     = (&(eq_same | ~len_mask)) && (seen_x >= len_x);
    hit.deletion  = split_match(eq_same, eq_ahead, LEN_W'(len - LEN_W'(1))) &&
                    (seen_x >= (len_x - (SEEN_W + 1)'(1)));
    hit.insertion = split_match(eq_same, eq_behind, len) &&
                    (seen_x >= (len_x + (SEEN_W + 1)'(1)));
  end

endmodule

// ----- hw/rtl/sipc_out.sv -----
// ----------------------------------------------------------------------------
// sipc_out
// Result register of the master stream: holds the three counts until taken.
// ----------------------------------------------------------------------------
module sipc_out (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  sipc_pkg::count_t                   exact_count,
  input  sipc_pkg::count_t                   deletion_count,
  input  sipc_pkg::count_t                   insertion_count,
  output logic                               free,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // exact_count, deletion_count, insertion_count
  output logic [sipc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import sipc_pkg::*;

  logic [OUT_TDATA_W-1:0] data;
  logic                   valid;

  // Free when empty or when the held request is taken this cycle.
  assign free = !valid || m_axis_tready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (free && load) begin
      data <= {insertion_count[OUT_W-1:0], deletion_count[OUT_W-1:0],
               exact_count[OUT_W-1:0]};
    end
  end

  assign m_axis_tvalid = valid;
  assign m_axis_tdata  = data;

endmodule

// ----- hw/rtl/single_indel_pattern_counter_core.sv -----
// ----------------------------------------------------------------------------
// single_indel_pattern_counter_core
// Counts exact, one-deletion and one-insertion pattern matches over a
// stream of bases and reports the three counts on the last base of a text.
// ----------------------------------------------------------------------------
// Path: the last base is accepted into the input register; its counts are
// then loaded into the result register that drives the master stream.
// Throughput: one base per cycle, unless a last base must wait for the result
// register to be taken; comparator and counters act on the input register.
// Reset: rst clears the history count, all counts and both stream flags,
// and sets the pattern to length one, all A.
module single_indel_pattern_counter_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // base, zero fill
  input  logic [sipc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // last_base
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // exact_count, deletion_count, insertion_count
  output logic [sipc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [sipc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sipc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sipc_pkg::*;

  // Saturating add of a small increment.
  function automatic count_t sat_add(input count_t value, input logic [1:0] inc);
    logic [COUNT_BITS:0] sum;
    sum = {1'b0, value} + (COUNT_BITS + 1)'(inc);
    return sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
  endfunction

  logic [PAT_W-1:0]        pattern_bases;
  len_t                    pattern_len;
  len_t                    len;

  logic                    in_valid;
  base_t                   in_base;
  logic                    in_last;
  logic                    consume;
  logic                    out_free;

  base_t [MAX_PATTERN-1:0] hist;
  seen_t                   seen;
  seen_t                   seen_next;
  count_t                  exact_total;
  count_t                  deletion_total;
  count_t                  insertion_total;
  count_t                  exact_total_next;
  count_t                  deletion_total_next;
  count_t                  insertion_total_next;
  logic [1:0]              deletion_inc;
  hit_t                    hit;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bases <= '0;
      pattern_len   <= LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_BASES: pattern_bases <= cfg_data[PAT_W-1:0];
        REG_PATTERN_LEN:   pattern_len   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective pattern length, clamped to 1..MAX_PATTERN.
  always_comb begin
    if (pattern_len == '0) begin
      len = LEN_W'(1);
    end else if (pattern_len > LEN_W'(MAX_PATTERN)) begin
      len = LEN_W'(MAX_PATTERN);
    end else begin
      len = pattern_len;
    end
  end

  // The registered base is used unless it is the last one and the result
  // register cannot take its counts.
  assign consume       = in_valid && (!in_last || out_free);
  assign s_axis_tready = !in_valid || consume;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_base <= s_axis_tdata[BASE_W-1:0];
      in_last <= s_axis_tlast;
    end
  end

  // History count including the current base, held at the window depth.
  assign seen_next = (seen == SEEN_W'(WIN_DEPTH)) ? seen : seen + SEEN_W'(1);

  sipc_match u_match (
    .base          (in_base),
    .hist          (hist),
    .pattern_bases (pattern_bases),
    .len           (len),
    .seen          (seen_next),
    .hit           (hit)
  );

  // Count updates; a one-base pattern adds one more deletion on the last base.
  always_comb begin
    deletion_inc         = {1'b0, hit.deletion} +
                           {1'b0, in_last && (len == LEN_W'(1))};
    exact_total_next     = sat_add(exact_total, {1'b0, hit.exact});
    deletion_total_next  = sat_add(deletion_total, deletion_inc);
    insertion_total_next = sat_add(insertion_total, {1'b0, hit.insertion});
  end

  // Text history shift line.
  always_ff @(posedge clk) begin
    if (consume) begin
      hist[0] <= in_base;
      for (int j = 1; j < MAX_PATTERN; j++) begin
        hist[j] <= hist[j-1];
      end
    end
  end

  // Running counts, cleared after the last base of a text.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen            <= '0;
      exact_total     <= '0;
      deletion_total  <= '0;
      insertion_total <= '0;
    end else if (consume) begin
      if (in_last) begin
        seen            <= '0;
        exact_total     <= '0;
        deletion_total  <= '0;
        insertion_total <= '0;
      end else begin
        seen            <= seen_next;
        exact_total     <= exact_total_next;
        deletion_total  <= deletion_total_next;
        insertion_total <= insertion_total_next;
      end
    end
  end

  sipc_out u_out (
    .clk             (clk),
    .rst             (rst),
    .load            (consume && in_last),
    .exact_count     (exact_total_next),
    .deletion_count  (deletion_total_next),
    .insertion_count (insertion_total_next),
    .free            (out_free),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata)
  );

endmodule

// ----- test/tb_single_indel_pattern_counter_core.sv -----
// ----------------------------------------------------------------------------
// tb_single_indel_pattern_counter_core
// Streams nucleotide texts into the counter and checks the exact, deletion
// and insertion counts that come back on the last base of each text. The
// expected counts come from a cycle-free predictor of the window compares
// that is kept in step with every accepted request and every register write.
// ----------------------------------------------------------------------------
module tb_single_indel_pattern_counter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sipc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 150;
  localparam int NUM_PHASES  = 11;
  localparam int SETTLE      = 4;

  typedef base_t bases_t [WIN_DEPTH];

  // Result layout, exact count in the lowest bits.
  typedef struct packed {
    logic [OUT_W-1:0] insertion;
    logic [OUT_W-1:0] deletion;
    logic [OUT_W-1:0] exact;
  } counts_t;

  // How a piece of generated text relates to the pattern.
  typedef enum int {SEG_NOISE, SEG_EXACT, SEG_DROP, SEG_EXTRA, SEG_SWAP} segment_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_PATTERN_BASES;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Predictor state: history (index 0 newest), counts and pattern copy.
  bases_t      hist = '{default: BASE_A};
  logic [31:0] seen = '0;
  count_t      exact_total = '0;
  count_t      deletion_total = '0;
  count_t      insertion_total = '0;
  logic [31:0] pat_bits = '0;
  len_t        pat_len = len_t'(1);

  counts_t pending_counts[$];
  int      mismatches = 0;
  int      cycles = 0;

  // Traffic shaping on both sides.
  bit tx_gaps = 1'b1;
  int tx_burst_left = 0;
  bit rx_steady = 1'b0;
  int rx_count = 0;
  int rx_period = 1;
  int rx_open = 1;

  single_indel_pattern_counter_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: ready for the tail of each short random period.
  always @(posedge clk) begin
    if (rx_count == 0) begin
      rx_period = $urandom_range(1, 8);
      rx_open = rx_steady ? rx_period : $urandom_range(0, rx_period);
      rx_count = rx_period;
    end
    m_axis_tready <= (rx_count <= rx_open);
    rx_count--;
  end

  // Compare each accepted result with the oldest expected counts.
  always @(posedge clk) begin : check_results
    counts_t got;
    counts_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = counts_t'(m_axis_tdata);
      if (pending_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: exact %0d deletion %0d insertion %0d",
                   got.exact, got.deletion, got.insertion);
      end else begin
        want = pending_counts.pop_front();
        if (got.exact != want.exact || got.deletion != want.deletion ||
            got.insertion != want.insertion) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch (expected/actual): exact %0d/%0d deletion %0d/%0d insertion %0d/%0d",
                     want.exact, got.exact, want.deletion, got.deletion,
                     want.insertion, got.insertion);
        end
      end
    end
  end

  // Effective pattern length after clamping.
  function automatic int pattern_span();
    if (pat_len == 0) return 1;
    if (pat_len > MAX_PATTERN) return MAX_PATTERN;
    return int'(pat_len);
  endfunction

  function automatic base_t pattern_base(int k);
    return pat_bits[2*k +: 2];
  endfunction

  function automatic count_t bumped(count_t c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  // True if dropping one base of lng (n+1 bases) leaves shrt (n bases).
  function automatic bit one_removed(bases_t lng, bases_t shrt, int n);
    int pre;
    int suf;
    pre = 0;
    suf = n;
    while (pre < n && lng[pre] == shrt[pre]) pre++;
    while (suf > 0 && lng[suf] == shrt[suf-1]) suf--;
    return suf <= pre;
  endfunction

  // Advance the predictor by one accepted base.
  task automatic count_base(input base_t b, input bit last);
    bases_t pat;
    bases_t win;
    int m;
    bit hit;
    m = pattern_span();
    pat = '{default: BASE_A};
    win = '{default: BASE_A};
    for (int k = 0; k < MAX_PATTERN; k++) pat[k] = pattern_base(k);
    for (int k = WIN_DEPTH - 1; k > 0; k--) hist[k] = hist[k-1];
    hist[0] = b;
    if (seen != 32'hFFFF_FFFF) seen++;

    // Exact window of m bases, oldest first.
    if (seen >= m) begin
      hit = 1'b1;
      for (int k = 0; k < m; k++)
        if (hist[m-1-k] != pat[k]) hit = 1'b0;
      if (hit) exact_total = bumped(exact_total);
    end

    // Window of m-1 bases against the pattern with one base dropped.
    if (seen >= m - 1) begin
      for (int k = 0; k < m - 1; k++) win[k] = hist[m-2-k];
      if (one_removed(pat, win, m - 1)) deletion_total = bumped(deletion_total);
    end

    // Window of m+1 bases with one dropped against the pattern.
    if (seen >= m + 1) begin
      for (int k = 0; k <= m; k++) win[k] = hist[m-k];
      if (one_removed(win, pat, m)) insertion_total = bumped(insertion_total);
    end

    if (last) begin
      // The empty variant of a one-base pattern also matches past the end.
      if (m == 1) deletion_total = bumped(deletion_total);
      pending_counts.push_back('{insertion: insertion_total[OUT_W-1:0],
                                 deletion: deletion_total[OUT_W-1:0],
                                 exact: exact_total[OUT_W-1:0]});
      hist = '{default: BASE_A};
      seen = '0;
      exact_total = '0;
      deletion_total = '0;
      insertion_total = '0;
    end
  endtask

  // Offer one base as a request, with bursts and gaps on the sender side.
  task automatic send_base(input base_t b, input bit last);
    if (tx_burst_left == 0) begin
      if (tx_gaps) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      tx_burst_left = $urandom_range(1, 24);
    end
    tx_burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_TDATA_W'(b);
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    count_base(b, last);
  endtask

  // Hold off the sender until every expected result is back and the
  // pipeline has drained any trailing bases.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write both pattern registers back to back.
  task automatic set_pattern(input logic [31:0] bits, input int len);
    cfg_we <= 1'b1;
    cfg_index <= REG_PATTERN_BASES;
    cfg_data <= bits;
    @(posedge clk);
    cfg_index <= REG_PATTERN_LEN;
    cfg_data <= CFG_DATA_W'(len);
    @(posedge clk);
    cfg_we <= 1'b0;
    pat_bits = bits;
    pat_len = len_t'(len);
  endtask

  // Build one text from pattern copies, near misses and noise, then send it.
  task automatic send_text(output int sent);
    base_t txt[$];
    int m;
    int target;
    int cut;
    segment_t seg;
    m = pattern_span();
    target = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 3*m + 6);
    if (target == 1) txt.push_back(base_t'($urandom_range(0, 3)));
    while (txt.size() < target) begin
      seg = segment_t'($urandom_range(0, 4));
      case (seg)
        SEG_NOISE: begin
          txt.push_back(base_t'($urandom_range(0, 3)));
        end
        SEG_EXACT: begin
          for (int k = 0; k < m; k++) txt.push_back(pattern_base(k));
        end
        SEG_DROP: begin
          cut = $urandom_range(0, m - 1);
          for (int k = 0; k < m; k++)
            if (k != cut) txt.push_back(pattern_base(k));
        end
        SEG_EXTRA: begin
          cut = $urandom_range(0, m);
          for (int k = 0; k <= m; k++) begin
            if (k == cut) txt.push_back(base_t'($urandom_range(0, 3)));
            if (k < m) txt.push_back(pattern_base(k));
          end
        end
        default: begin
          cut = $urandom_range(0, m - 1);
          for (int k = 0; k < m; k++)
            txt.push_back(k == cut ? base_t'($urandom_range(0, 3)) : pattern_base(k));
        end
      endcase
    end
    foreach (txt[i]) send_base(txt[i], i == txt.size() - 1);
    sent = txt.size();
  endtask

  // Pattern left at its reset value: one base, A.
  task automatic test_reset_pattern();
    send_base(BASE_A, 1'b0);
    send_base(BASE_T, 1'b1);
    send_base(BASE_T, 1'b1);
  endtask

  // A length of zero behaves as a one-base pattern.
  task automatic test_zero_length();
    wait_for_results();
    set_pattern($urandom(), 0);
    send_base(BASE_C, 1'b0);
    send_base(BASE_A, 1'b0);
    send_base(BASE_G, 1'b1);
  endtask

  // A length past the maximum is clamped; an all-T pattern fills the window.
  task automatic test_oversize_length();
    wait_for_results();
    set_pattern(32'hFFFF_FFFF, 31);
    for (int i = 0; i < MAX_PATTERN; i++) send_base(BASE_T, i == MAX_PATTERN - 1);
  endtask

  // Phases of random texts under different patterns and traffic shapes.
  task automatic test_random_texts();
    int phase_items;
    int sent;
    int len;
    logic [31:0] bits;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_for_results();
      bits = $urandom();
      case (phase)
        0: len = 1;
        1: len = 2;
        2: begin
          len = MAX_PATTERN;
          bits = '1;
        end
        3: len = MAX_PATTERN;
        4: len = 0;
        5: len = $urandom_range(MAX_PATTERN + 1, 31);
        6: begin
          len = $urandom_range(3, 8);
          bits = '0;
        end
        9: len = 31;
        default: len = $urandom_range(3, MAX_PATTERN - 1);
      endcase
      set_pattern(bits, len);
      tx_gaps = (phase % 3 != 0);
      rx_steady = (phase % 3 == 0);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        send_text(sent);
        phase_items += sent;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_pattern();
    test_zero_length();
    test_oversize_length();
    test_random_texts();
    wait_for_results();
    if (mismatches == 0 && pending_counts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/sipc_pkg.sv
hw/rtl/sipc_match.sv
hw/rtl/sipc_out.sv
hw/rtl/single_indel_pattern_counter_core.sv
test/tb_single_indel_pattern_counter_core.sv
